// ===== rtl/emp_pkg.sv =====
package emp_pkg;

   localparam int Channels = 4;
   localparam int PinBits  = 4;
   localparam int ChanW    = 2;
   localparam int ChanIdxW = (Channels > 1) ? $clog2(Channels) : 1;
   localparam int LevelW   = (Channels > PinBits) ? Channels : PinBits;

   localparam int OpW      = 2;
   localparam int WordW    = 32;
   localparam int KwhW     = 16;
   localparam int MinW     = 16;
   localparam int NumW     = 64;
   localparam int DenW     = 48;
   localparam int QuotW    = 32;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   localparam logic [OpW-1:0] OP_TICK    = 2'd0;
   localparam logic [OpW-1:0] OP_SAMPLE  = 2'd1;
   localparam logic [OpW-1:0] OP_HARVEST = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_INVERT    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_PPKWH     = 2'd2;

   localparam logic [WordW-1:0] WordMax     = 32'hFFFF_FFFF;
   localparam logic [WordW-1:0] ActiveReset = 32'd1000000;
   localparam logic [WordW-1:0] WhPerKwh    = 32'd1000;
   localparam logic [WordW-1:0] MsWhScale   = 32'd3600000000;

   localparam logic [MinW-1:0]    MinPulseReset = 16'd50;
   localparam logic [PinBits-1:0] InvertReset   = 4'd0;
   localparam logic [KwhW-1:0]    PpkwhReset    = 16'd1000;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QuotW-1:0] quot;
   } div_rsp_type;

   function automatic logic [WordW-1:0] sat_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
      logic [WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WordW] ? WordMax : s[WordW-1:0];
   endfunction

endpackage

// ===== rtl/emp_if.sv =====
interface emp_req_if;
   logic                          valid;
   logic                          ready;
   logic [emp_pkg::OpW-1:0]       operation;
   logic [emp_pkg::PinBits-1:0]   pin_levels;
   logic [emp_pkg::ChanW-1:0]     channel;

   modport source (output valid, output operation, output pin_levels, output channel,
                   input ready);
   modport sink (input valid, input operation, input pin_levels, input channel,
                 output ready);
endinterface

interface emp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [emp_pkg::ChanW-1:0]     reported_channel;
   logic [emp_pkg::WordW-1:0]     new_pulses;
   logic [emp_pkg::WordW-1:0]     pulse_total;
   logic [emp_pkg::WordW-1:0]     energy_wh;
   logic [emp_pkg::WordW-1:0]     power_w;
   logic                          power_valid;
   logic [emp_pkg::WordW-1:0]     last_pulse_ms;

   modport source (output valid, output reported_channel, output new_pulses,
                   output pulse_total, output energy_wh, output power_w,
                   output power_valid, output last_pulse_ms, input ready);
   modport sink (input valid, input reported_channel, input new_pulses,
                 input pulse_total, input energy_wh, input power_w,
                 input power_valid, input last_pulse_ms, output ready);
endinterface

interface emp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [emp_pkg::CsrIdxW-1:0]    index;
   logic [emp_pkg::CsrDataW-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/emp_div.sv =====
// Restoring divider, one quotient bit per cycle. Quotient saturates at all ones,
// which also covers a zero divisor.
module emp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  emp_pkg::div_req_type  div_req,
   output emp_pkg::div_rsp_type  div_rsp
);

   localparam int CntW = $clog2(emp_pkg::QuotW);
   localparam int NumW = emp_pkg::NumW;
   localparam int DenW = emp_pkg::DenW;
   localparam int QW   = emp_pkg::QuotW;

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_CHK  = 3'b010,
      DV_RUN  = 3'b100
   } dv_state_type;

   dv_state_type      state_ff, state_in;
   logic              done_ff, done_in;
   logic [NumW-1:0]   num_ff, num_in;
   logic [DenW-1:0]   den_ff, den_in;
   logic [DenW-1:0]   rem_ff, rem_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [DenW:0]     trial;
   logic [DenW:0]     diff;
   logic              qbit;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      trial    = {rem_ff, num_ff[QW-1]};
      diff     = trial - {1'b0, den_ff};
      qbit     = (trial >= {1'b0, den_ff});

      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               num_in   = div_req.num;
               den_in   = div_req.den;
               state_in = DV_CHK;
            end
         end
         DV_CHK: begin
            // high half not below divisor: quotient needs more than 32 bits
            if (DenW'(num_ff[NumW-1:QW]) >= den_ff) begin
               quot_in  = emp_pkg::WordMax;
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               rem_in   = DenW'(num_ff[NumW-1:QW]);
               cnt_in   = CntW'(QW - 1);
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in         = qbit ? diff[DenW-1:0] : trial[DenW-1:0];
            num_in[QW-1:0] = {num_ff[QW-2:0], qbit};
            if (cnt_ff == '0) begin
               quot_in  = {num_ff[QW-2:0], qbit};
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== rtl/energy_meter_pulse_counter.sv =====
// Tick, pin-sample and empty harvest items are handled in the idle state; items may follow back to back.
// A harvest with new pulses holds the input through ST_MUL_E, ST_DIV_E and ST_OUT for energy alone,
// adding ST_MUL_PN, ST_MUL_PD and ST_DIV_P when power is valid (one shared multiplier,
// one-bit-per-cycle divider; a saturating quotient skips its 32 divide steps).
// A finished result waits in the output register while the next item is taken.
// Synchronous reset restores all settings and channel state.
module energy_meter_pulse_counter (
   input  logic         clock,
   input  logic         reset,
   emp_req_if.sink      req_if,
   emp_rsp_if.source    rsp_if,
   emp_csr_if.sink      csr_if
);

   localparam int Ch    = emp_pkg::Channels;
   localparam int IdxW  = emp_pkg::ChanIdxW;
   localparam int LvW   = emp_pkg::LevelW;
   localparam int WW    = emp_pkg::WordW;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL_E  = 7'b0000010,
      ST_DIV_E  = 7'b0000100,
      ST_MUL_PN = 7'b0001000,
      ST_MUL_PD = 7'b0010000,
      ST_DIV_P  = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;

   logic [emp_pkg::MinW-1:0]        min_pulse_ff;
   logic [emp_pkg::PinBits-1:0]     invert_ff;
   logic [emp_pkg::KwhW-1:0]        ppkwh_ff;

   logic [WW-1:0]                   time_ff, time_in;
   logic [Ch-1:0]                   level_ff, level_in;
   logic [WW-1:0]                   active_ff [Ch];
   logic [WW-1:0]                   active_in [Ch];
   logic [WW-1:0]                   pulse_ff [Ch];
   logic [WW-1:0]                   pulse_in [Ch];
   logic [WW-1:0]                   unread_ff [Ch];
   logic [WW-1:0]                   unread_in [Ch];
   logic [WW-1:0]                   total_ff [Ch];
   logic [WW-1:0]                   total_in [Ch];
   logic [WW-1:0]                   lastrep_ff [Ch];
   logic [WW-1:0]                   lastrep_in [Ch];

   // work registers of the harvest in progress
   logic [emp_pkg::ChanW-1:0]       ch_ff, ch_in;
   logic [WW-1:0]                   fresh_ff, fresh_in;
   logic [WW-1:0]                   sum_ff, sum_in;
   logic [WW-1:0]                   lp_ff, lp_in;
   logic [WW-1:0]                   interval_ff, interval_in;
   logic                            pvalid_ff, pvalid_in;
   logic [emp_pkg::NumW-1:0]        pnum_ff, pnum_in;
   logic [WW-1:0]                   energy_ff, energy_in;
   logic [WW-1:0]                   power_ff, power_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            out_load;
   logic [emp_pkg::ChanW-1:0]       out_ch_ff;
   logic [WW-1:0]                   out_fresh_ff;
   logic [WW-1:0]                   out_total_ff;
   logic [WW-1:0]                   out_energy_ff;
   logic [WW-1:0]                   out_power_ff;
   logic                            out_pvalid_ff;
   logic [WW-1:0]                   out_lp_ff;

   logic                            req_ready;
   logic                            req_fire;
   logic [IdxW-1:0]                 ch_idx;
   logic                            ch_ok;
   logic [WW-1:0]                   fresh;
   logic [LvW-1:0]                  level_now;
   logic [WW-1:0]                   mul_a, mul_b;
   logic [emp_pkg::NumW-1:0]        prod;

   emp_pkg::div_req_type            div_req;
   emp_pkg::div_rsp_type            div_rsp;

   emp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_if.ready  = req_ready;
   assign req_fire      = req_if.valid && req_ready;
   assign csr_if.ready  = 1'b1;

   assign ch_idx    = IdxW'(req_if.channel);
   assign ch_ok     = (int'(req_if.channel) < Ch);
   assign fresh     = unread_ff[ch_idx];
   // channels past the pin bits read level 0 with no inversion
   assign level_now = LvW'(req_if.pin_levels) ^ LvW'(invert_ff);

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_PN: begin
            mul_a = fresh_ff;
            mul_b = emp_pkg::MsWhScale;
         end
         ST_MUL_PD: begin
            mul_a = interval_ff;
            mul_b = WW'(ppkwh_ff);
         end
         default: begin
            mul_a = sum_ff;
            mul_b = emp_pkg::WhPerKwh;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign div_req.start = (state_ff == ST_MUL_E) || (state_ff == ST_MUL_PD);
   assign div_req.num   = (state_ff == ST_MUL_E) ? prod : pnum_ff;
   assign div_req.den   = (state_ff == ST_MUL_E) ? emp_pkg::DenW'(ppkwh_ff)
                                                 : prod[emp_pkg::DenW-1:0];

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      level_in    = level_ff;
      active_in   = active_ff;
      pulse_in    = pulse_ff;
      unread_in   = unread_ff;
      total_in    = total_ff;
      lastrep_in  = lastrep_ff;
      ch_in       = ch_ff;
      fresh_in    = fresh_ff;
      sum_in      = sum_ff;
      lp_in       = lp_ff;
      interval_in = interval_ff;
      pvalid_in   = pvalid_ff;
      pnum_in     = pnum_ff;
      energy_in   = energy_ff;
      power_in    = power_ff;
      out_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.operation)
                  emp_pkg::OP_TICK: begin
                     time_in = emp_pkg::sat_add(time_ff, WW'(1));
                  end
                  emp_pkg::OP_SAMPLE: begin
                     for (int c = 0; c < Ch; c++) begin
                        if (level_now[c] != level_ff[c]) begin
                           level_in[c] = level_now[c];
                           if (level_now[c]) begin
                              active_in[c] = time_ff;
                           end else if (time_ff > emp_pkg::sat_add(active_ff[c],
                                                     WW'(min_pulse_ff)) &&
                                        time_ff > emp_pkg::sat_add(pulse_ff[c],
                                                     WW'(min_pulse_ff))) begin
                              unread_in[c] = emp_pkg::sat_add(unread_ff[c], WW'(1));
                              pulse_in[c]  = time_ff;
                           end
                        end
                     end
                  end
                  emp_pkg::OP_HARVEST: begin
                     if (ch_ok && fresh != '0) begin
                        unread_in[ch_idx]  = '0;
                        total_in[ch_idx]   = emp_pkg::sat_add(total_ff[ch_idx], fresh);
                        lastrep_in[ch_idx] = pulse_ff[ch_idx];
                        ch_in       = req_if.channel;
                        fresh_in    = fresh;
                        sum_in      = emp_pkg::sat_add(total_ff[ch_idx], fresh);
                        lp_in       = pulse_ff[ch_idx];
                        interval_in = pulse_ff[ch_idx] - lastrep_ff[ch_idx];
                        pvalid_in   = (lastrep_ff[ch_idx] != '0) &&
                                      (pulse_ff[ch_idx] > lastrep_ff[ch_idx]);
                        state_in    = ST_MUL_E;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL_E: state_in = ST_DIV_E;
         ST_DIV_E: begin
            if (div_rsp.done) begin
               energy_in = div_rsp.quot;
               power_in  = '0;
               state_in  = pvalid_ff ? ST_MUL_PN : ST_OUT;
            end
         end
         ST_MUL_PN: begin
            pnum_in  = prod;
            state_in = ST_MUL_PD;
         end
         ST_MUL_PD: state_in = ST_DIV_P;
         ST_DIV_P: begin
            if (div_rsp.done) begin
               power_in = div_rsp.quot;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_pulse_ff <= emp_pkg::MinPulseReset;
         invert_ff    <= emp_pkg::InvertReset;
         ppkwh_ff     <= emp_pkg::PpkwhReset;
         time_ff      <= '0;
         level_ff     <= '0;
         for (int c = 0; c < Ch; c++) begin
            active_ff[c]  <= emp_pkg::ActiveReset;
            pulse_ff[c]   <= '0;
            unread_ff[c]  <= '0;
            total_ff[c]   <= '0;
            lastrep_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         level_ff     <= level_in;
         active_ff    <= active_in;
         pulse_ff     <= pulse_in;
         unread_ff    <= unread_in;
         total_ff     <= total_in;
         lastrep_ff   <= lastrep_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               emp_pkg::CSR_MIN_PULSE: min_pulse_ff <= csr_if.data;
               emp_pkg::CSR_INVERT:    invert_ff    <= csr_if.data[emp_pkg::PinBits-1:0];
               emp_pkg::CSR_PPKWH:     ppkwh_ff     <= csr_if.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      fresh_ff    <= fresh_in;
      sum_ff      <= sum_in;
      lp_ff       <= lp_in;
      interval_ff <= interval_in;
      pvalid_ff   <= pvalid_in;
      pnum_ff     <= pnum_in;
      energy_ff   <= energy_in;
      power_ff    <= power_in;
      if (out_load) begin
         out_ch_ff     <= ch_ff;
         out_fresh_ff  <= fresh_ff;
         out_total_ff  <= sum_ff;
         out_energy_ff <= energy_ff;
         out_power_ff  <= power_ff;
         out_pvalid_ff <= pvalid_ff;
         out_lp_ff     <= lp_ff;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.reported_channel = out_ch_ff;
   assign rsp_if.new_pulses       = out_fresh_ff;
   assign rsp_if.pulse_total      = out_total_ff;
   assign rsp_if.energy_wh        = out_energy_ff;
   assign rsp_if.power_w          = out_power_ff;
   assign rsp_if.power_valid      = out_pvalid_ff;
   assign rsp_if.last_pulse_ms    = out_lp_ff;

endmodule
